### design/pid_pkg.sv
// Shared types, widths and register codes for the incremental PID controller.
// Every module of the design imports this package; it depends on nothing else.
package pid_pkg;

    // Fixed-point setup
    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 12;

    // Field widths
    localparam int GAIN_W  = 24;
    localparam int LIMIT_W = 15;
    localparam int DRIVE_W = 16;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    // Datapath widths
    localparam int ERR_W   = SAMPLE_BITS + 1;
    localparam int COEF_W  = GAIN_W + 3;
    localparam int PROD_W  = COEF_W + ERR_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int DELTA_W = ACC_W - GAIN_FRAC_BITS;
    localparam int U_W     = DELTA_W + 1;

    // Reset values
    localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(1 << GAIN_FRAC_BITS);
    localparam logic [LIMIT_W-1:0]       LIMIT_RESET  = {LIMIT_W{1'b1}};

    // Register map, word index from paddr[3:2]
    typedef enum logic [1:0] {
        REG_GAIN_P       = 2'd0,
        REG_GAIN_I       = 2'd1,
        REG_GAIN_D       = 2'd2,
        REG_OUTPUT_LIMIT = 2'd3
    } reg_index_t;

    // Sample word
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] reference;
        logic signed [SAMPLE_BITS-1:0] measured;
    } sample_word_t;

    // Command word
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } cmd_word_t;

    // Error history entry passed from front to back
    typedef struct packed {
        logic signed [ERR_W-1:0] e0;
        logic signed [ERR_W-1:0] e1;
        logic signed [ERR_W-1:0] e2;
    } err_set_t;

    // Filter coefficients and clamp from the register block
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic [LIMIT_W-1:0]       limit;
    } coef_t;

endpackage

### design/pid_regs.sv
// Configuration registers behind the APB port and the derived coefficients.
// Depends on pid_pkg.
module pid_regs
    import pid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output coef_t             coef
);

    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [LIMIT_W-1:0]       limit_reg;
    logic                     wr_en;
    reg_index_t               idx;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RESET;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GAIN_P:       gain_p_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:       gain_i_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:       gain_d_reg <= pwdata[GAIN_W-1:0];
                REG_OUTPUT_LIMIT: limit_reg  <= pwdata[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_GAIN_P:       prdata = DATA_W'(gain_p_reg);
            REG_GAIN_I:       prdata = DATA_W'(gain_i_reg);
            REG_GAIN_D:       prdata = DATA_W'(gain_d_reg);
            REG_OUTPUT_LIMIT: prdata = DATA_W'(limit_reg);
            default:          prdata = '0;
        endcase
    end

    // b0 = p + i + d, b1 = i - p - 2d, b2 = d
    always_comb
    begin
        coef.b0    = COEF_W'(gain_p_reg) + COEF_W'(gain_i_reg) + COEF_W'(gain_d_reg);
        coef.b1    = COEF_W'(gain_i_reg) - COEF_W'(gain_p_reg)
                   - (COEF_W'(gain_d_reg) <<< 1);
        coef.b2    = COEF_W'(gain_d_reg);
        coef.limit = limit_reg;
    end

endmodule

### design/pid_front.sv
// Front end: takes sample words, forms the error and keeps the error history.
// Depends on pid_pkg; feeds pid_queue.
module pid_front
    import pid_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_word_t sample_word,
    output logic         push,
    output err_set_t     push_data,
    input  logic         q_full
);

    logic signed [ERR_W-1:0] e1_reg;
    logic signed [ERR_W-1:0] e2_reg;
    logic signed [ERR_W-1:0] e0;

    assign sample_stall = q_full;
    assign push         = sample_valid && !q_full;
    assign e0           = ERR_W'(sample_word.reference) - ERR_W'(sample_word.measured);

    always_comb
    begin
        push_data.e0 = e0;
        push_data.e1 = e1_reg;
        push_data.e2 = e2_reg;
    end

    // Error history shifts on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg <= '0;
            e2_reg <= '0;
        end
        else if (push)
        begin
            e1_reg <= e0;
            e2_reg <= e1_reg;
        end
    end

endmodule

### design/pid_queue.sv
// Two-entry queue of error sets between front and back.
// Depends on pid_pkg.
module pid_queue
    import pid_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  err_set_t push_data,
    output logic     full,
    output logic     head_valid,
    output err_set_t head,
    input  logic     pop
);

    err_set_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### design/pid_back.sv
// Back end: multiply stage, sum and round stage, accumulate and clamp stage.
// Depends on pid_pkg; pulls error sets from pid_queue.
module pid_back
    import pid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  err_set_t  head,
    output logic      pop,
    input  coef_t     coef,
    output logic      cmd_valid,
    input  logic      cmd_stall,
    output cmd_word_t cmd_word
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (GAIN_FRAC_BITS - 1);

    logic                      s1_valid_reg;
    logic signed [PROD_W-1:0]  p0_reg;
    logic signed [PROD_W-1:0]  p1_reg;
    logic signed [PROD_W-1:0]  p2_reg;
    logic                      s2_valid_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic                      out_valid_reg;
    cmd_word_t                 out_reg;
    logic signed [DRIVE_W-1:0] last_drive_reg;

    logic                      out_ready;
    logic                      s2_ready;
    logic                      s1_ready;
    logic signed [PROD_W-1:0]  p0_next;
    logic signed [PROD_W-1:0]  p1_next;
    logic signed [PROD_W-1:0]  p2_next;
    logic signed [ACC_W-1:0]   acc;
    logic signed [DELTA_W-1:0] delta_next;
    logic signed [U_W-1:0]     u;
    logic signed [U_W-1:0]     lim;
    cmd_word_t                 out_next;

    // Stage handshakes
    assign out_ready = !out_valid_reg || !cmd_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop       = head_valid && s1_ready;

    assign cmd_valid = out_valid_reg;
    assign cmd_word  = out_reg;

    // Multiply
    always_comb
    begin
        p0_next = coef.b0 * head.e0;
        p1_next = coef.b1 * head.e1;
        p2_next = coef.b2 * head.e2;
    end

    // Sum, round half up, drop fraction
    always_comb
    begin
        acc        = ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg) + HALF;
        delta_next = $signed(acc[ACC_W-1:GAIN_FRAC_BITS]);
    end

    // Accumulate onto previous command and clamp
    always_comb
    begin
        u   = U_W'(last_drive_reg) + U_W'(delta_reg);
        lim = U_W'($signed({1'b0, coef.limit}));
        out_next.drive   = u[DRIVE_W-1:0];
        out_next.clamped = 1'b0;
        if (u > lim)
        begin
            out_next.drive   = lim[DRIVE_W-1:0];
            out_next.clamped = 1'b1;
        end
        else if (u < -lim)
        begin
            out_next.drive   = -lim[DRIVE_W-1:0];
            out_next.clamped = 1'b1;
        end
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_drive_reg <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= head_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_ready)
                out_valid_reg <= s2_valid_reg;
            if (out_ready && s2_valid_reg)
                last_drive_reg <= out_next.drive;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (s2_ready && s1_valid_reg)
            delta_reg <= delta_next;
        if (out_ready && s2_valid_reg)
            out_reg <= out_next;
    end

endmodule

### design/incremental_pid_controller_core.sv
// Incremental PID controller, top level. Depends on pid_pkg and the pid_* modules.
// Throughput: one sample word per cycle while the command side does not stall; the
// accumulate and clamp stage closes the loop on the previous command it holds.
// Path: the accepted sample word passes the queue, multiply, sum and round, and
// clamp registers in order; the command side can hold it back while it stalls.
// Reset: asynchronous, active low; clears error history and last command, unity P gain.
module incremental_pid_controller_core
    import pid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  sample_word_t      sample_word,
    output logic              cmd_valid,
    input  logic              cmd_stall,
    output cmd_word_t         cmd_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    coef_t    coef;
    logic     push;
    err_set_t push_data;
    logic     q_full;
    logic     head_valid;
    err_set_t head;
    logic     pop;

    pid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    pid_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .push         (push),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    pid_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    pid_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .coef       (coef),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_word   (cmd_word)
    );

    // A clamped command sits exactly on the limit
    a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_word.clamped |->
            (cmd_word.drive == $signed({1'b0, coef.limit})) ||
            (cmd_word.drive == -$signed({1'b0, coef.limit})))
        else $error("clamped command not at limit");

    // No command ever leaves the limit band
    a_drive_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |->
            (cmd_word.drive <= $signed({1'b0, coef.limit})) &&
            (cmd_word.drive >= -$signed({1'b0, coef.limit})))
        else $error("command outside limit band");

    // Queue never drains an entry it does not hold
    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for incremental_pid_controller_core: APB gain setup, sample words in,
// command words checked against an in-bench velocity-form PID predictor. Depends on pid_pkg.
module tb;
    import pid_pkg::*;

    localparam int LONG_HOLD    = 200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE       = 8;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_ITEMS  = 150;
    localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    sample_word_t      sample_word  = '0;
    logic              cmd_valid;
    logic              cmd_stall    = 1'b0;
    cmd_word_t         cmd_word;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    incremental_pid_controller_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd_word     (cmd_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Controller shadow: gains, clamp and loop history
    logic signed [GAIN_W-1:0]  kp        = GAIN_P_RESET;
    logic signed [GAIN_W-1:0]  ki        = '0;
    logic signed [GAIN_W-1:0]  kd        = '0;
    logic [LIMIT_W-1:0]        clamp_lim = LIMIT_RESET;
    logic signed [ERR_W-1:0]   err_1     = '0;
    logic signed [ERR_W-1:0]   err_2     = '0;
    logic signed [DRIVE_W-1:0] held_drive = '0;

    sample_word_t feed_q[$];
    cmd_word_t    pending_cmds[$];
    int           mismatches  = 0;
    int           setpoint    = 0;
    int           holds_asked = 0;

    // Next command from one sample; advances the loop history
    function automatic cmd_word_t next_command(sample_word_t s);
        longint    e0, c0, c1, c2, acc, u, lim;
        cmd_word_t r;
        e0  = longint'($signed(s.reference)) - longint'($signed(s.measured));
        c0  = longint'(kp) + longint'(ki) + longint'(kd);
        c1  = -longint'(kp) + longint'(ki) - 2 * longint'(kd);
        c2  = longint'(kd);
        acc = c0 * e0 + c1 * longint'(err_1) + c2 * longint'(err_2);
        u   = longint'(held_drive)
              + ((acc + (longint'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS);
        lim = longint'({1'b0, clamp_lim});
        r.clamped = 1'b0;
        if (u > lim)
        begin
            u = lim;
            r.clamped = 1'b1;
        end
        else if (u < -lim)
        begin
            u = -lim;
            r.clamped = 1'b1;
        end
        err_2      = err_1;
        err_1      = ERR_W'(e0);
        held_drive = DRIVE_W'(u);
        r.drive    = DRIVE_W'(u);
        return r;
    endfunction

    // Per-word random wait, with occasional runs of back-to-back words
    function automatic int pick_wait(inout int steady);
        if (steady > 0)
        begin
            steady--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            steady = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // Sender
    int send_wait   = 0;
    int send_steady = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else
        begin
            if (sample_valid && !sample_stall)
                pending_cmds.push_back(next_command(sample_word));
            if (!(sample_valid && sample_stall))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    sample_valid <= 1'b0;
                end
                else if (feed_q.size() > 0)
                begin
                    sample_word  <= feed_q.pop_front();
                    sample_valid <= 1'b1;
                    send_wait = pick_wait(send_steady);
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Receiver and checker
    int recv_wait   = 0;
    int recv_steady = 0;
    int hold_left   = 0;
    int holds_done  = 0;
    always @(posedge clk or negedge rst_n)
    begin : cmd_mon
        cmd_word_t want;
        if (!rst_n)
            cmd_stall <= 1'b0;
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (pending_cmds.size() == 0)
                begin
                    $error("command word with none pending: drive %0d clamped %0d",
                           $signed(cmd_word.drive), cmd_word.clamped);
                    mismatches++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (cmd_word.drive !== want.drive)
                    begin
                        $error("drive: expected %0d, got %0d",
                               $signed(want.drive), $signed(cmd_word.drive));
                        mismatches++;
                    end
                    if (cmd_word.clamped !== want.clamped)
                    begin
                        $error("clamped: expected %0d, got %0d",
                               want.clamped, cmd_word.clamped);
                        mismatches++;
                    end
                end
                recv_wait = pick_wait(recv_steady);
            end
            // long hold-off first, then the per-word wait
            if (hold_left > 0)
            begin
                hold_left--;
                cmd_stall <= 1'b1;
            end
            else if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                cmd_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                cmd_stall <= 1'b1;
            end
            else
                cmd_stall <= 1'b0;
        end
    end

    // Watchdog: no word moving while work is outstanding
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (cmd_valid && !cmd_stall) ||
            (feed_q.size() == 0 && pending_cmds.size() == 0 && !sample_valid))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("incremental_pid_controller_core: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // APB write: setup then access; shadow follows at the write edge
    task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN_P:       kp = val[GAIN_W-1:0];
            REG_GAIN_I:       ki = val[GAIN_W-1:0];
            REG_GAIN_D:       kd = val[GAIN_W-1:0];
            REG_OUTPUT_LIMIT: clamp_lim = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits are don't-care; fill them with noise
    task automatic apply_config(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                                logic [GAIN_W-1:0] d, logic [LIMIT_W-1:0] lim);
        write_reg(REG_GAIN_P, {(DATA_W-GAIN_W)'($urandom), p});
        write_reg(REG_GAIN_I, {(DATA_W-GAIN_W)'($urandom), i});
        write_reg(REG_GAIN_D, {(DATA_W-GAIN_W)'($urandom), d});
        write_reg(REG_OUTPUT_LIMIT, {(DATA_W-LIMIT_W)'($urandom), lim});
    endtask

    // Wait until every command is back and the pipe has settled
    task automatic drain();
        while (feed_q.size() != 0 || pending_cmds.size() != 0 || sample_valid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void offer(int r, int m);
        sample_word_t s;
        s.reference = SAMPLE_BITS'(r);
        s.measured  = SAMPLE_BITS'(m);
        feed_q.push_back(s);
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return GAIN_MAX;
            1:       return GAIN_MIN;
            2:       return '0;
            default: return GAIN_W'(int'($urandom_range(0, 16384)) - 8192);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return LIMIT_W'(1);
            1:       return LIMIT_RESET;
            2:       return LIMIT_W'($urandom_range(1, 32767));
            default: return LIMIT_W'($urandom_range(50, 2000));
        endcase
    endfunction

    // Mostly a tracking loop around a wandering setpoint, some raw noise
    function automatic void offer_random();
        if ($urandom_range(0, 9) < 2)
            feed_q.push_back(sample_word_t'($urandom));
        else
        begin
            if ($urandom_range(0, 15) == 0)
                setpoint = int'($urandom_range(0, 4000)) - 2000;
            offer(setpoint, setpoint + int'($urandom_range(0, 400)) - 200);
        end
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset gains: unity proportional, full-scale errors both ways
        offer(0, 0);
        offer(32767, -32768);
        offer(-32768, 32767);
        offer(100, -100);
        offer(-1, 0);
        offer(0, 0);
        drain();

        // extreme gains, tightest nonzero limit
        apply_config(GAIN_MAX, GAIN_MAX, GAIN_MIN, LIMIT_W'(1));
        offer(32767, -32768);
        offer(-32768, 32767);
        offer(1, 0);
        offer(0, 0);
        drain();

        // opposite extremes, zero limit pins every command to 0
        apply_config(GAIN_MIN, GAIN_MIN, GAIN_MAX, '0);
        offer(-32768, 32767);
        offer(32767, -32768);
        offer(0, 1);
        offer(0, 0);
        drain();

        // moderate PID, step response
        apply_config(GAIN_W'(4096), GAIN_W'(410), GAIN_W'(2048), LIMIT_RESET);
        offer(1000, 0);
        offer(1000, 300);
        offer(1000, 600);
        offer(1000, 900);
        offer(1000, 1100);
        offer(1000, 1000);
        drain();

        // random phases; one of them with a long receiver hold-off
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            apply_config(rand_gain(), rand_gain(), rand_gain(), rand_limit());
            if (ph == 2)
                holds_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_random();
            drain();
        end

        if (mismatches == 0)
            $display("incremental_pid_controller_core: match");
        else
            $display("incremental_pid_controller_core: mismatch");
        $finish;
    end

endmodule
